/* sv/erc_pkg.sv */
// erc_pkg: shared types, codes and sizing for the event-to-record index cursor
// no dependencies; compile first

package erc_pkg;

  // table sizing
  localparam int MAX_RECORDS = 256;
  localparam int REC_W       = $clog2(MAX_RECORDS);
  localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
  localparam int DATA_W      = 32;

  typedef logic [REC_W-1:0]  rec_idx_t;
  typedef logic [CNT_W-1:0]  rec_cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  // action codes of a command beat
  typedef enum logic [2:0] {
    ACT_CLEAR   = 3'd0,
    ACT_APPEND  = 3'd1,
    ACT_RESET   = 3'd2,
    ACT_ADVANCE = 3'd3,
    ACT_RETREAT = 3'd4,
    ACT_SEEK    = 3'd5
  } action_t;

  // status codes of a response beat
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LIMIT = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // engine sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SEARCH,
    FSM_EMIT
  } fsm_t;

  // totals memory access
  typedef struct packed {
    logic     we;
    rec_idx_t waddr;
    data_t    wdata;
    rec_idx_t raddr;
  } ram_req_t;

  // one response beat
  typedef struct packed {
    data_t       event_number;
    logic [7:0]  record_number;
    data_t       record_offset;
    logic        record_changed;
    status_t     status;
    data_t       total_events;
    logic        can_advance;
    logic        can_retreat;
  } result_t;

endpackage

/* sv/erc_if.sv */
// erc_if: valid/ready channel interfaces for command and response beats
// depends on nothing; payload fields carry fixed widths

interface erc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface erc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_number;
  logic [7:0]  record_number;
  logic [31:0] record_offset;
  logic        record_changed;
  logic [1:0]  status;
  logic [31:0] total_events;
  logic        can_advance;
  logic        can_retreat;

  modport source (output valid, output event_number, output record_number,
                  output record_offset, output record_changed, output status,
                  output total_events, output can_advance, output can_retreat,
                  input ready);
  modport sink   (input valid, input event_number, input record_number,
                  input record_offset, input record_changed, input status,
                  input total_events, input can_advance, input can_retreat,
                  output ready);
endinterface

/* sv/erc_ram.sv */
// erc_ram: generic single-write, single-read synchronous ram
// registered read: data appears the cycle after the address; no dependencies

module erc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/erc_engine.sv */
// erc_engine: action sequencer, cursor state and binary search over the totals
// depends on erc_pkg and erc_in_if; drives the totals ram through ram_req_t

module erc_engine import erc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  erc_in_if.sink   cmd,
  output ram_req_t ram_req,
  input  data_t    ram_rdata,
  input  logic     slot_free,
  output logic     emit,
  output result_t  result
);

  fsm_t     fsm, fsm_next;
  action_t  act, act_next;
  data_t    val, val_next;
  rec_idx_t old_record, old_record_next;
  data_t    cur_event, cur_event_next;
  rec_idx_t cur_record, cur_record_next;
  data_t    cur_offset, cur_offset_next;
  rec_cnt_t held, held_next;
  data_t    total, total_next;
  status_t  status, status_next;
  data_t    tgt, tgt_next;
  rec_idx_t lo, lo_next;
  rec_idx_t hi, hi_next;
  data_t    lo_start, lo_start_next;

  logic            start_seek;
  data_t           seek_tgt;
  logic [DATA_W:0] sum_wide;
  logic [DATA_W:0] next_event_wide;
  logic            table_full;
  rec_idx_t        mid;

  // upper midpoint of a search window
  function automatic rec_idx_t mid_of(rec_idx_t l, rec_idx_t h);
    logic [REC_W:0] span;
    span = {1'b0, h} - {1'b0, l} + (REC_W + 1)'(1);
    return l + span[REC_W:1];
  endfunction

  assign sum_wide        = {1'b0, total} + {1'b0, val};
  assign next_event_wide = {1'b0, cur_event} + (DATA_W + 1)'(1);
  assign table_full      = (held == CNT_W'(MAX_RECORDS));
  assign mid             = mid_of(lo, hi);

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= FSM_IDLE;
      held       <= '0;
      total      <= '0;
      cur_event  <= '0;
      cur_record <= '0;
      cur_offset <= '0;
    end else begin
      fsm        <= fsm_next;
      held       <= held_next;
      total      <= total_next;
      cur_event  <= cur_event_next;
      cur_record <= cur_record_next;
      cur_offset <= cur_offset_next;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    act        <= act_next;
    val        <= val_next;
    old_record <= old_record_next;
    status     <= status_next;
    tgt        <= tgt_next;
    lo         <= lo_next;
    hi         <= hi_next;
    lo_start   <= lo_start_next;
  end

  // sequencer
  always_comb begin
    fsm_next        = fsm;
    act_next        = act;
    val_next        = val;
    old_record_next = old_record;
    cur_event_next  = cur_event;
    cur_record_next = cur_record;
    cur_offset_next = cur_offset;
    held_next       = held;
    total_next      = total;
    status_next     = status;
    tgt_next        = tgt;
    lo_next         = lo;
    hi_next         = hi;
    lo_start_next   = lo_start;
    start_seek      = 1'b0;
    seek_tgt        = '0;
    cmd.ready       = 1'b0;
    emit            = 1'b0;
    ram_req.we      = 1'b0;
    ram_req.waddr   = held[REC_W-1:0];
    ram_req.wdata   = sum_wide[DATA_W-1:0];

    case (fsm)
      FSM_IDLE: begin
        // no beat is taken while reset is held
        cmd.ready = !rst;
        if (cmd.valid && !rst) begin
          act_next        = action_t'(cmd.action);
          val_next        = cmd.value;
          old_record_next = cur_record;
          fsm_next        = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        status_next = ST_OK;
        fsm_next    = FSM_EMIT;
        case (act)
          ACT_CLEAR: begin
            held_next       = '0;
            total_next      = '0;
            cur_event_next  = '0;
            cur_record_next = '0;
            cur_offset_next = '0;
          end
          ACT_APPEND: begin
            if (table_full || sum_wide[DATA_W]) begin
              status_next = ST_FULL;
            end else begin
              ram_req.we = 1'b1;
              held_next  = held + CNT_W'(1);
              total_next = sum_wide[DATA_W-1:0];
            end
          end
          ACT_RESET: begin
            if (total == '0) begin
              cur_event_next  = '0;
              cur_record_next = '0;
              cur_offset_next = '0;
              status_next     = ST_LIMIT;
            end else begin
              start_seek = 1'b1;
            end
          end
          ACT_ADVANCE: begin
            if (next_event_wide >= {1'b0, total}) begin
              status_next = ST_LIMIT;
            end else begin
              start_seek = 1'b1;
              seek_tgt   = next_event_wide[DATA_W-1:0];
            end
          end
          ACT_RETREAT: begin
            if (cur_event == '0) begin
              status_next = ST_LIMIT;
            end else begin
              start_seek = 1'b1;
              seek_tgt   = cur_event - DATA_W'(1);
            end
          end
          ACT_SEEK: begin
            if (val >= total) begin
              status_next = ST_RANGE;
            end else begin
              start_seek = 1'b1;
              seek_tgt   = val;
            end
          end
          default: begin
          end
        endcase
        // every move lands on the last record whose start is not above the target
        if (start_seek) begin
          tgt_next      = seek_tgt;
          lo_next       = '0;
          hi_next       = REC_W'(held - CNT_W'(1));
          lo_start_next = '0;
          fsm_next      = FSM_SEARCH;
        end
      end

      FSM_SEARCH: begin
        if (lo < hi) begin
          // read data is the start of record mid, i.e. total of mid - 1
          if (ram_rdata <= tgt) begin
            lo_next       = mid;
            lo_start_next = ram_rdata;
          end else begin
            hi_next = mid - REC_W'(1);
          end
        end else begin
          cur_record_next = lo;
          cur_event_next  = tgt;
          cur_offset_next = tgt - lo_start;
          fsm_next        = FSM_EMIT;
        end
      end

      FSM_EMIT: begin
        emit = slot_free;
        if (slot_free) begin
          fsm_next = FSM_IDLE;
        end
      end

      default: begin
        fsm_next = FSM_IDLE;
      end
    endcase

    // read address follows the next search window so each probe finds its data ready
    ram_req.raddr = mid_of(lo_next, hi_next) - REC_W'(1);
  end

  // response beat from the updated cursor
  always_comb begin
    result.event_number   = cur_event;
    result.record_number  = 8'(cur_record);
    result.record_offset  = cur_offset;
    result.record_changed = (cur_record != old_record);
    result.status         = status;
    result.total_events   = total;
    result.can_advance    = (next_event_wide < {1'b0, total});
    result.can_retreat    = (cur_event != '0);
  end

endmodule

/* sv/erc_out_reg.sv */
// erc_out_reg: response output register between the engine and the receiver
// depends on erc_pkg and erc_out_if

module erc_out_reg import erc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  result_t  result,
  output logic     slot_free,
  erc_out_if.source rsp
);

  result_t held_beat;
  logic    valid;

  assign slot_free = !valid || rsp.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held_beat <= result;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.event_number   = held_beat.event_number;
  assign rsp.record_number  = held_beat.record_number;
  assign rsp.record_offset  = held_beat.record_offset;
  assign rsp.record_changed = held_beat.record_changed;
  assign rsp.status         = held_beat.status;
  assign rsp.total_events   = held_beat.total_events;
  assign rsp.can_advance    = held_beat.can_advance;
  assign rsp.can_retreat    = held_beat.can_retreat;

endmodule

/* sv/event_to_record_index_cursor_core.sv */
// event_to_record_index_cursor_core: top level of the event-to-record cursor
// depends on erc_pkg, erc_if, erc_ram, erc_engine and erc_out_reg
//
// Usage:
//   cmd carries one action per beat (clear, append, reset, advance, retreat,
//   seek) with a 32-bit value; rsp returns exactly one beat per command with
//   the cursor, status and table total after the action.
//   Running totals live in a 256 x 32 synchronous ram; record starts are read
//   from it one probe per cycle during a binary search.
//   Clear, append, any refused move and unknown actions respond without a
//   search; a move runs a binary search of k probes, where k is at most
//   ceil(log2(records held)), so at most 8. One command is in work at a time;
//   the next is taken the cycle after the response is loaded.
//   Reset (synchronous, active high) empties the table and zeroes the cursor;
//   no command beat is taken while it is held. Ram contents are not cleared,
//   entries are valid only once appended.
//   When the receiver stalls, the response waits in the output register and
//   one more command is accepted and worked; it then waits to load.

module event_to_record_index_cursor_core import erc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  erc_in_if.sink    cmd,
  erc_out_if.source rsp
);

  ram_req_t ram_req;
  data_t    ram_rdata;
  logic     slot_free;
  logic     emit;
  result_t  result;

  // running totals store
  erc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_RECORDS)
  ) u_totals (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // action sequencer and cursor
  erc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .slot_free (slot_free),
    .emit      (emit),
    .result    (result)
  );

  // response register
  erc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .result    (result),
    .slot_free (slot_free),
    .rsp       (rsp)
  );

endmodule

/* sv/erc_checker.sv */
// erc_checker: port-level assertions on the cursor response channel
// depends on erc_pkg; bound to event_to_record_index_cursor_core below

module erc_checker import erc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_event_number,
  input logic        rsp_record_changed,
  input logic [1:0]  rsp_status,
  input logic [31:0] rsp_total_events,
  input logic        rsp_can_advance
);

  // no response beat right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a stalled response beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_number)
      && $stable(rsp_status))
    else $error("stalled response beat changed");

  // room to advance means the cursor lies inside the table
  a_adv_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_can_advance |-> rsp_event_number < rsp_total_events)
    else $error("can_advance with cursor at or past total");

  // a refused action never moves the cursor to another record
  a_chg_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_record_changed |-> rsp_status == ST_OK)
    else $error("record changed on a refused action");

endmodule

bind event_to_record_index_cursor_core erc_checker u_chk (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_event_number   (rsp.event_number),
  .rsp_record_changed (rsp.record_changed),
  .rsp_status         (rsp.status),
  .rsp_total_events   (rsp.total_events),
  .rsp_can_advance    (rsp.can_advance)
);
